// File: rtl/core/lsqf_pkg.sv
// ----------------------------------------------------------------------------
// lsqf_pkg
// shared types and constants of the least-squares line fit block
// ----------------------------------------------------------------------------
package lsqf_pkg;

  localparam int COORD_W = 16;
  localparam int COEF_W  = 32;
  localparam int CFG_W   = 32;
  localparam int STAT_W  = 2;

  // 1.0 and the default flatness limit
  localparam logic signed [COEF_W-1:0] ONE_Q16    = 32'sd65536;
  localparam logic [CFG_W-1:0]         FLAT_RESET = 32'd168;

  typedef enum logic [STAT_W-1:0] {
    ST_GENERAL    = 2'd0,
    ST_VERTICAL   = 2'd1,
    ST_HORIZONTAL = 2'd2,
    ST_EMPTY      = 2'd3
  } fit_status_t;

endpackage

// File: rtl/core/lsqf_if.sv
// ----------------------------------------------------------------------------
// lsqf channel interfaces
// point request channel and line result channel, valid/ready
// ----------------------------------------------------------------------------
interface point_if;
  import lsqf_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;
  logic                      point_valid;
  logic                      last_point;

  modport source (output valid, x_coord, y_coord, point_valid, last_point, input ready);
  modport sink   (input valid, x_coord, y_coord, point_valid, last_point, output ready);
endinterface

interface line_if;
  import lsqf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] coef_a;
  logic signed [COEF_W-1:0] coef_b;
  logic signed [COEF_W-1:0] coef_c;
  logic [STAT_W-1:0]        fit_status;

  modport source (output valid, coef_a, coef_b, coef_c, fit_status, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, fit_status, output ready);
endinterface

// File: rtl/core/lsqf_ram.sv
// ----------------------------------------------------------------------------
// lsqf_ram
// generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module lsqf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/lsqf_div.sv
// ----------------------------------------------------------------------------
// lsqf_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lsqf_div #(
  parameter int NW = 61,
  parameter int DW = 45
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CNTW = $clog2(NW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [DW-1:0]   rem;
  logic [NW-1:0]   q;
  logic [DW-1:0]   d;
  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic            ge;

  assign trial = {rem, q[NW-1]};
  assign diff  = trial - {1'b0, d};
  assign ge    = (trial >= {1'b0, d});
  assign quo   = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= num;
      d   <= den;
    end else if (busy) begin
      rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
      q   <= {q[NW-2:0], ge};
    end
  end
endmodule

// File: rtl/core/least_squares_line_fit.sv
// ----------------------------------------------------------------------------
// least_squares_line_fit
// ordinary least-squares line fit over a loaded set of 2-D points
// ----------------------------------------------------------------------------
// usage
//   points: valid/ready request channel, one point per request; point_valid
//     marks a real point, last_point closes the set and starts the fit
//   fit: valid/ready result channel, one line a*x+b*y+c=0 (Q16.16) plus
//     status per closed set
//   cfg_we/cfg_wdata: writes flat_threshold; the user must write it only while
//     the block is idle; the block itself does not enforce this
// throughput and fit sequence
//   points load at one request per cycle while idle
//   a fit runs two mean divisions, a pass over the point RAM with one shared
//   multiplier (three products per point) and, unless the line is vertical or
//   horizontal, one slope division, all on the same restoring divider (width
//   NW, 63 at the default size); an empty set skips all of these steps
// reset
//   clears the point count, sums and result valid; threshold goes to 168
// stall
//   the result waits in an output register; new points still load, but the
//   next fit waits in S_HOLD, taking no points, until that result is taken
// ----------------------------------------------------------------------------
module least_squares_line_fit #(
  parameter int MAX_POINTS      = 1024,
  parameter int COORD_FRAC_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  point_if.sink                     points,
  line_if.source                    fit,
  input  logic                      cfg_we,
  input  logic [lsqf_pkg::CFG_W-1:0] cfg_wdata
);
  import lsqf_pkg::*;

  // widths
  localparam int CW   = $clog2(MAX_POINTS + 1);               // point count
  localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int SW   = COORD_W + CW;                         // coordinate sums
  localparam int MW   = COORD_W + 1;                          // means
  localparam int DXW  = COORD_W + 2;                          // deviations
  localparam int ACW  = 2 * DXW + CW;                         // centred sums
  localparam int NW   = ACW + 16;                             // divider numerator
  localparam int PRW  = COEF_W + DXW;                         // multiplier product
  localparam int XW   = PRW + 1;                              // intercept math
  localparam int SHL  = (COORD_FRAC_BITS <= 16) ? 16 - COORD_FRAC_BITS : 0;
  localparam int SHR  = (COORD_FRAC_BITS > 16) ? COORD_FRAC_BITS - 16 : 0;

  localparam logic signed [XW-1:0] SAT_HI = XW'(64'sh7fffffff);
  localparam logic signed [XW-1:0] SAT_LO = -XW'(64'sh80000000);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_MX_GO, S_MX_W, S_MY_GO, S_MY_W,
    S_P_RD, S_P_LD, S_P_M0, S_P_M1, S_P_M2, S_P_ACC,
    S_DECIDE, S_SL_GO, S_SL_W, S_IC_MUL, S_IC_FIN, S_HOLD
  } state_t;

  // magnitude shift right, truncated toward zero
  function automatic logic signed [XW-1:0] trunc_shr(input logic signed [XW-1:0] v,
                                                      input int unsigned sh);
    logic [XW-1:0] m;
    m = v[XW-1] ? XW'(-v) : XW'(v);
    m = m >> sh;
    return v[XW-1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [XW-1:0] to_q16(input logic signed [XW-1:0] v);
    return trunc_shr(v <<< SHL, SHR);
  endfunction

  function automatic logic signed [COEF_W-1:0] sat32(input logic signed [XW-1:0] v);
    if (v > SAT_HI) begin
      return 32'sh7fffffff;
    end else if (v < SAT_LO) begin
      return 32'sh80000000;
    end
    return v[COEF_W-1:0];
  endfunction

  state_t                    state;
  logic [CFG_W-1:0]          thr;
  logic [CW-1:0]             count;
  logic [CW-1:0]             idx;
  logic signed [SW-1:0]      sum_x;
  logic signed [SW-1:0]      sum_y;
  logic signed [MW-1:0]      mx;
  logic signed [MW-1:0]      my;
  logic signed [DXW-1:0]     dx;
  logic signed [DXW-1:0]     dy;
  logic signed [PRW-1:0]     prod;
  logic [ACW-1:0]            vx;
  logic [ACW-1:0]            vy;
  logic signed [ACW-1:0]     cov;
  logic signed [COEF_W-1:0]  slope;

  // pending result and output register
  logic signed [COEF_W-1:0]  res_a, res_b, res_c;
  fit_status_t               res_st;
  logic                      out_valid;
  logic signed [COEF_W-1:0]  out_a, out_b, out_c;
  fit_status_t               out_st;
  logic                      load_out;

  // point ram
  logic                      store_ok;
  logic [2*COORD_W-1:0]      rd_data;

  // shared multiplier
  logic signed [COEF_W-1:0]  mul_a;
  logic signed [DXW-1:0]     mul_b;
  logic signed [PRW-1:0]     mul_p;

  // shared divider
  logic                      div_start;
  logic [NW-1:0]             div_num;
  logic [ACW-1:0]            div_den;
  logic                      div_done;
  logic [NW-1:0]             div_quo;

  logic                      accept;
  logic [SW-1:0]             mag_sx, mag_sy;
  logic [ACW-1:0]            mag_cov;
  logic [MW-1:0]             mean_mag;
  logic signed [XW-1:0]      mxq, myq, c_full;
  logic [ACW-1:0]            thr_ext;
  logic signed [COEF_W-1:0]  slope_sat;

  assign points.ready   = (state == S_IDLE);
  assign accept         = points.valid && points.ready;
  assign store_ok       = accept && points.point_valid && (count < CW'(MAX_POINTS));

  // result moves to the output register once that register is free
  assign load_out       = (state == S_HOLD) && (!out_valid || fit.ready);

  assign fit.valid      = out_valid;
  assign fit.coef_a     = out_a;
  assign fit.coef_b     = out_b;
  assign fit.coef_c     = out_c;
  assign fit.fit_status = out_st;

  lsqf_ram #(.WIDTH(2 * COORD_W), .DEPTH(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (store_ok),
    .waddr (count[AW-1:0]),
    .wdata ({points.y_coord, points.x_coord}),
    .raddr (idx[AW-1:0]),
    .rdata (rd_data)
  );

  lsqf_div #(.NW(NW), .DW(ACW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // magnitudes for the divider
  assign mag_sx   = sum_x[SW-1] ? SW'(-sum_x) : SW'(sum_x);
  assign mag_sy   = sum_y[SW-1] ? SW'(-sum_y) : SW'(sum_y);
  assign mag_cov  = cov[ACW-1] ? ACW'(-cov) : ACW'(cov);
  assign mean_mag = div_quo[MW-1:0];

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = ACW'(count);
    case (state)
      S_MX_GO: begin
        div_start = 1'b1;
        div_num   = NW'(mag_sx);
      end
      S_MY_GO: begin
        div_start = 1'b1;
        div_num   = NW'(mag_sy);
      end
      S_SL_GO: begin
        div_start = 1'b1;
        div_num   = {mag_cov, 16'b0};
        div_den   = vx;
      end
      default: begin
      end
    endcase
  end

  // one multiplier, operands picked by the sequencer
  always_comb begin
    mul_a = COEF_W'(dx);
    mul_b = dx;
    case (state)
      S_P_M1:   begin mul_a = COEF_W'(dy); mul_b = dy;         end
      S_P_M2:   begin mul_a = COEF_W'(dx); mul_b = dy;         end
      S_IC_MUL: begin mul_a = slope;       mul_b = DXW'(mx);   end
      default: begin
      end
    endcase
  end

  assign mul_p = PRW'(mul_a) * PRW'(mul_b);

  // slope saturation: quotient is the magnitude of cov/varX in Q16.16
  always_comb begin
    if (!cov[ACW-1]) begin
      slope_sat = (|div_quo[NW-1:31]) ? 32'sh7fffffff : $signed(div_quo[COEF_W-1:0]);
    end else if ((|div_quo[NW-1:32]) || (div_quo[31] && (|div_quo[30:0]))) begin
      slope_sat = 32'sh80000000;
    end else begin
      slope_sat = -$signed(div_quo[COEF_W-1:0]);
    end
  end

  assign mxq     = to_q16(XW'(mx));
  assign myq     = to_q16(XW'(my));
  assign c_full  = myq - trunc_shr(XW'(prod), COORD_FRAC_BITS);
  assign thr_ext = ACW'(thr);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      thr       <= FLAT_RESET;
      count     <= '0;
      sum_x     <= '0;
      sum_y     <= '0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (cfg_we) begin
        thr <= cfg_wdata;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (fit.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (store_ok) begin
            count <= count + 1'b1;
            sum_x <= sum_x + SW'(points.x_coord);
            sum_y <= sum_y + SW'(points.y_coord);
          end
          if (accept && points.last_point) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (count == '0) begin
            res_a  <= '0;
            res_b  <= '0;
            res_c  <= '0;
            res_st <= ST_EMPTY;
            state  <= S_HOLD;
          end else begin
            state <= S_MX_GO;
          end
        end
        S_MX_GO: state <= S_MX_W;
        S_MX_W: begin
          if (div_done) begin
            mx    <= sum_x[SW-1] ? -$signed(mean_mag) : $signed(mean_mag);
            state <= S_MY_GO;
          end
        end
        S_MY_GO: state <= S_MY_W;
        S_MY_W: begin
          if (div_done) begin
            my    <= sum_y[SW-1] ? -$signed(mean_mag) : $signed(mean_mag);
            idx   <= '0;
            vx    <= '0;
            vy    <= '0;
            cov   <= '0;
            state <= S_P_RD;
          end
        end
        // second pass: deviations and centred sums, one point at a time
        S_P_RD: state <= S_P_LD;
        S_P_LD: begin
          dx    <= DXW'($signed(rd_data[COORD_W-1:0])) - DXW'(mx);
          dy    <= DXW'($signed(rd_data[2*COORD_W-1:COORD_W])) - DXW'(my);
          state <= S_P_M0;
        end
        S_P_M0: begin
          prod  <= mul_p;
          state <= S_P_M1;
        end
        S_P_M1: begin
          vx    <= vx + ACW'(prod);
          prod  <= mul_p;
          state <= S_P_M2;
        end
        S_P_M2: begin
          vy    <= vy + ACW'(prod);
          prod  <= mul_p;
          state <= S_P_ACC;
        end
        S_P_ACC: begin
          cov <= cov + ACW'(prod);
          idx <= idx + 1'b1;
          if (idx + 1'b1 < count) begin
            state <= S_P_RD;
          end else begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (vx == '0 || vx < thr_ext) begin
            res_a  <= -ONE_Q16;
            res_b  <= '0;
            res_c  <= sat32(mxq);
            res_st <= ST_VERTICAL;
            state  <= S_HOLD;
          end else if (vy < thr_ext) begin
            res_a  <= '0;
            res_b  <= -ONE_Q16;
            res_c  <= sat32(myq);
            res_st <= ST_HORIZONTAL;
            state  <= S_HOLD;
          end else begin
            state <= S_SL_GO;
          end
        end
        S_SL_GO: state <= S_SL_W;
        S_SL_W: begin
          if (div_done) begin
            slope <= slope_sat;
            state <= S_IC_MUL;
          end
        end
        S_IC_MUL: begin
          prod  <= mul_p;
          state <= S_IC_FIN;
        end
        S_IC_FIN: begin
          res_a  <= slope;
          res_b  <= -ONE_Q16;
          res_c  <= sat32(c_full);
          res_st <= ST_GENERAL;
          state  <= S_HOLD;
        end
        // hand the result over and clear the set
        S_HOLD: begin
          if (load_out) begin
            out_a     <= res_a;
            out_b     <= res_b;
            out_c     <= res_c;
            out_st    <= res_st;
            count     <= '0;
            sum_x     <= '0;
            sum_y     <= '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/core/lsqf_checker.sv
// ----------------------------------------------------------------------------
// lsqf_checker
// port-level checks of the line fit block, bound to the top level
// ----------------------------------------------------------------------------
module lsqf_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              fit_valid,
  input logic                              fit_ready,
  input logic signed [lsqf_pkg::COEF_W-1:0] coef_a,
  input logic signed [lsqf_pkg::COEF_W-1:0] coef_b,
  input logic signed [lsqf_pkg::COEF_W-1:0] coef_c,
  input logic [lsqf_pkg::STAT_W-1:0]        fit_status
);
  import lsqf_pkg::*;

  // stalled result holds (valid, coef_a, coef_c and status)
  a_hold: assert property (@(posedge clk) disable iff (rst)
    fit_valid && !fit_ready |=> fit_valid && $stable(coef_a) && $stable(coef_c)
      && $stable(fit_status))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !fit_valid)
    else $error("result valid right after reset");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    fit_valid && fit_status == ST_EMPTY |-> coef_a == '0 && coef_b == '0 && coef_c == '0)
    else $error("empty set with nonzero line");

  a_vert: assert property (@(posedge clk) disable iff (rst)
    fit_valid && fit_status == ST_VERTICAL |-> coef_a == -ONE_Q16 && coef_b == '0)
    else $error("vertical line with wrong coefficients");

  a_coef_b: assert property (@(posedge clk) disable iff (rst)
    fit_valid && (fit_status == ST_GENERAL || fit_status == ST_HORIZONTAL)
      |-> coef_b == -ONE_Q16)
    else $error("y coefficient is not -1.0");
endmodule

bind least_squares_line_fit lsqf_checker u_lsqf_checker (
  .clk        (clk),
  .rst        (rst),
  .fit_valid  (fit.valid),
  .fit_ready  (fit.ready),
  .coef_a     (fit.coef_a),
  .coef_b     (fit.coef_b),
  .coef_c     (fit.coef_c),
  .fit_status (fit.fit_status)
);

// File: test/least_squares_line_fit_tb.sv
// ----------------------------------------------------------------------------
// least_squares_line_fit_tb
// drives point sets through the line fit block and compares each fitted line
// with a line worked out in the bench from the same points and threshold
// ----------------------------------------------------------------------------
module least_squares_line_fit_tb;
  import lsqf_pkg::*;

  localparam int MAX_PTS   = 1024;
  localparam int FRAC_BITS = 12;
  localparam int DRAIN_CYC = 400;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
    fit_status_t              fit_status;
  } line_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  point_if points ();
  line_if  fit ();

  least_squares_line_fit #(.MAX_POINTS(MAX_PTS), .COORD_FRAC_BITS(FRAC_BITS)) i_dut (
    .clk(clk), .rst(rst), .points(points.sink), .fit(fit.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bench copy of the block state
  logic signed [15:0] set_x[$];
  logic signed [15:0] set_y[$];
  logic [CFG_W-1:0]   flat_limit;
  line_t              lines_due[$];
  int                 fail_count;
  int                 lines_seen;
  int                 requests_sent;
  int                 stall_left;

  initial begin
    points.valid = 1'b0;
    points.x_coord = '0;
    points.y_coord = '0;
    points.point_valid = 1'b0;
    points.last_point = 1'b0;
    fit.ready = 1'b0;
    flat_limit = FLAT_RESET;
    fail_count = 0;
    lines_seen = 0;
    requests_sent = 0;
    stall_left = 0;
  end

  // signed 64-bit magnitude shift, truncated toward zero
  function automatic longint shr_toward_zero(longint v, int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = m >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // cov / varx in Q16.16 by long division, clamped
  function automatic longint slope_q16(longint num, longint unsigned den);
    longint unsigned mag, q, r, frac, res;
    mag = (num < 0) ? -num : num;
    q = mag / den;
    r = mag % den;
    frac = 0;
    if (q > 32768) return (num < 0) ? -64'sd2147483648 : 64'sd2147483647;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      frac = frac << 1;
      if (r >= den) begin
        r = r - den;
        frac = frac | 1;
      end
    end
    res = (q << 16) | frac;
    return clamp32((num < 0) ? -longint'(res) : longint'(res));
  endfunction

  // fit over the points held in the bench copy
  function automatic line_t fit_held_points();
    line_t ln;
    longint n, sx, sy, mx, my, dx, dy, cov, slope, c;
    longint unsigned vx, vy;
    n = set_x.size();
    sx = 0; sy = 0; cov = 0; vx = 0; vy = 0;
    ln = '0;
    if (n == 0) begin
      ln.fit_status = ST_EMPTY;
      return ln;
    end
    for (int i = 0; i < n; i++) begin
      sx += set_x[i];
      sy += set_y[i];
    end
    mx = sx / n;
    my = sy / n;
    for (int i = 0; i < n; i++) begin
      dx = set_x[i] - mx;
      dy = set_y[i] - my;
      cov += dx * dy;
      vx += longint'(dx * dx);
      vy += longint'(dy * dy);
    end
    if (vx == 0 || vx < flat_limit) begin
      ln.coef_a = -ONE_Q16;
      ln.coef_c = clamp32(mx <<< (16 - FRAC_BITS));
      ln.fit_status = ST_VERTICAL;
    end else if (vy < flat_limit) begin
      ln.coef_b = -ONE_Q16;
      ln.coef_c = clamp32(my <<< (16 - FRAC_BITS));
      ln.fit_status = ST_HORIZONTAL;
    end else begin
      slope = slope_q16(cov, vx);
      c = (my <<< (16 - FRAC_BITS)) - shr_toward_zero(slope * mx, FRAC_BITS);
      ln.coef_a = slope;
      ln.coef_b = -ONE_Q16;
      ln.coef_c = clamp32(c);
      ln.fit_status = ST_GENERAL;
    end
    return ln;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // send one point request and update the expected lines
  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
                            logic pv, logic last, bit use_gap = 1'b1);
    int gap;
    gap = use_gap ? pick_gap() : 0;
    if (gap > 0) begin
      points.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    points.valid <= 1'b1;
    points.x_coord <= x;
    points.y_coord <= y;
    points.point_valid <= pv;
    points.last_point <= last;
    @(posedge clk);
    while (!points.ready) @(posedge clk);
    requests_sent++;
    if (pv && set_x.size() < MAX_PTS) begin
      set_x.insert(set_x.size(), x);
      set_y.insert(set_y.size(), y);
    end
    if (last) begin
      lines_due.insert(lines_due.size(), fit_held_points());
      set_x.delete();
      set_y.delete();
    end
  endtask

  task automatic drop_valid();
    points.valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for all lines, then idle cycles, then write the threshold
  task automatic write_threshold(logic [CFG_W-1:0] value);
    drop_valid();
    while (lines_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    flat_limit = value;
  endtask

  // result side: random stalls, compare with oldest expected line
  always @(posedge clk) begin
    if (rst) begin
      fit.ready <= 1'b0;
    end else begin
      if (fit.valid && fit.ready) begin
        if (lines_due.size() == 0) begin
          $error("line result with none expected");
          fail_count++;
        end else begin
          line_t want;
          want = lines_due.pop_front();
          lines_seen++;
          if (fit.coef_a !== want.coef_a) begin
            $error("coef_a expected %0d actual %0d", want.coef_a, fit.coef_a);
            fail_count++;
          end
          if (fit.coef_b !== want.coef_b) begin
            $error("coef_b expected %0d actual %0d", want.coef_b, fit.coef_b);
            fail_count++;
          end
          if (fit.coef_c !== want.coef_c) begin
            $error("coef_c expected %0d actual %0d", want.coef_c, fit.coef_c);
            fail_count++;
          end
          if (fit.fit_status !== want.fit_status) begin
            $error("fit_status expected %0d actual %0d", want.fit_status, fit.fit_status);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        fit.ready <= 1'b0;
        stall_left--;
      end else begin
        fit.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // corners: empty set, bare marker, extremes, flat lines, steep slope
  task automatic test_directed();
    send_point(0, 0, 1'b0, 1'b1);
    send_point(-16'sd32768, 16'sd32767, 1'b1, 1'b1);
    send_point(16'sd32767, -16'sd32768, 1'b1, 1'b0);
    send_point(-16'sd32768, 16'sd32767, 1'b1, 1'b0);
    send_point(0, 0, 1'b0, 1'b1);
    send_point(100, -32768, 1'b1, 1'b0);
    send_point(100, 32767, 1'b1, 1'b1);
    send_point(-32768, 500, 1'b1, 1'b0);
    send_point(32767, 500, 1'b1, 1'b1);
    send_point(0, -32768, 1'b1, 1'b0);
    send_point(1, 32767, 1'b1, 1'b0);
    send_point(2, 0, 1'b1, 1'b1);
    send_point(-32768, -32768, 1'b1, 1'b0);
    send_point(0, 0, 1'b0, 1'b0);
    send_point(32767, 32767, 1'b1, 1'b0);
    send_point(-1, -1, 1'b1, 1'b1);
    send_point(0, 5, 1'b1, 1'b0);
    send_point(-32768, 32767, 1'b1, 1'b1);
  endtask

  // random sets: half lines with noise, the rest scattered, near-vertical or near-horizontal; some small
  task automatic test_random_sets(int total);
    int start, npts, kind, slope_i, base;
    logic signed [15:0] x, y;
    start = requests_sent;
    while (requests_sent - start < total) begin
      npts = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      kind = $urandom_range(0, 5);
      slope_i = $urandom_range(0, 8) - 4;
      base = $urandom_range(0, 8000) - 4000;
      for (int i = 0; i < npts; i++) begin
        case (kind)
          0: begin
            x = $urandom_range(0, 65535);
            y = $urandom_range(0, 65535);
          end
          1: begin
            x = base + $urandom_range(0, 3);
            y = $urandom_range(0, 20000) - 10000;
          end
          2: begin
            x = $urandom_range(0, 20000) - 10000;
            y = base + $urandom_range(0, 3);
          end
          default: begin
            x = $urandom_range(0, 6000) - 3000;
            y = base + slope_i * x + $urandom_range(0, 40) - 20;
          end
        endcase
        send_point(x, y, ($urandom_range(0, 15) != 0), 1'b0);
      end
      send_point($urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 1), 1'b1);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_sets(120);
    write_threshold(32'd0);
    test_directed();
    test_random_sets(80);
    write_threshold(32'hFFFF_FFFF);
    test_random_sets(50);
    write_threshold(32'd5_000_000);
    test_random_sets(70);
    write_threshold(FLAT_RESET);
    test_random_sets(40);
    drop_valid();
    while (lines_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    $display("covered %0d point requests and %0d fitted lines over five threshold settings",
             requests_sent, lines_seen);
    if (fail_count == 0) begin
      $display("least_squares_line_fit_tb: PASS");
    end else begin
      $display("least_squares_line_fit_tb: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("least_squares_line_fit_tb: FAIL");
    $finish;
  end

endmodule
